// ===== hw/rtl/rcsd_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, limits, character codes and helper functions for the
// seven-digit radix converter; no dependencies

package rcsd_pkg;

   localparam int FIELD_DIGITS = 7;
   localparam int VALUE_W      = 28;
   localparam int BASE_W       = 5;
   localparam int COUNT_W      = 4;
   localparam int CHAR_IN_W    = 8;
   localparam int CHAR_OUT_W   = 7;
   localparam int DIGIT_W      = 4;
   localparam int ERR_LEN      = 5;
   localparam int IDX_W        = (FIELD_DIGITS > 1) ? $clog2(FIELD_DIGITS) : 1;

   // divider retires this many quotient bits per cycle
   localparam int DIV_BITS     = 4;
   localparam int DIV_STEPS    = VALUE_W / DIV_BITS;
   localparam int DIV_CNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   localparam logic [VALUE_W-1:0]    VALUE_MAX   = {VALUE_W{1'b1}};
   localparam logic [COUNT_W-1:0]    COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0]    COUNT_LIMIT = COUNT_W'(FIELD_DIGITS);
   localparam logic [BASE_W-1:0]     BASE_MIN    = BASE_W'(2);
   localparam logic [BASE_W-1:0]     BASE_MAX    = BASE_W'(16);
   localparam logic [IDX_W-1:0]      POS_LAST    = IDX_W'(FIELD_DIGITS - 1);

   localparam logic [CHAR_IN_W-1:0]  ASC_ZERO_IN = 8'h30;
   localparam logic [CHAR_IN_W-1:0]  ASC_NINE_IN = 8'h39;
   localparam logic [CHAR_IN_W-1:0]  ASC_A_IN    = 8'h41;
   localparam logic [CHAR_IN_W-1:0]  ASC_F_IN    = 8'h46;

   localparam logic [CHAR_OUT_W-1:0] ASC_SPACE   = 7'h20;
   localparam logic [CHAR_OUT_W-1:0] ASC_ZERO    = 7'h30;
   localparam logic [CHAR_OUT_W-1:0] ASC_A       = 7'h41;
   localparam logic [CHAR_OUT_W-1:0] ASC_E       = 7'h45;
   localparam logic [CHAR_OUT_W-1:0] ASC_O       = 7'h4F;
   localparam logic [CHAR_OUT_W-1:0] ASC_R       = 7'h52;

   // digit value 0..15, or 16 for a character that is not a digit
   function automatic logic [BASE_W-1:0] char_to_digit(input logic [CHAR_IN_W-1:0] c);
      logic [BASE_W-1:0] d;
      d = 5'd16;
      if (c >= ASC_ZERO_IN && c <= ASC_NINE_IN) begin
         d = BASE_W'(c - ASC_ZERO_IN);
      end else if (c >= ASC_A_IN && c <= ASC_F_IN) begin
         d = BASE_W'(c - ASC_A_IN) + BASE_W'(10);
      end
      return d;
   endfunction

   function automatic logic [CHAR_OUT_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_OUT_W-1:0] c;
      if (d <= DIGIT_W'(9)) begin
         c = ASC_ZERO + CHAR_OUT_W'(d);
      end else begin
         c = ASC_A + CHAR_OUT_W'(d - DIGIT_W'(10));
      end
      return c;
   endfunction

   // character at field position pos of a right-justified ERROR field
   function automatic logic [CHAR_OUT_W-1:0] err_char(input logic [IDX_W-1:0] pos);
      int p;
      logic [CHAR_OUT_W-1:0] c;
      p = int'(pos) - (FIELD_DIGITS - ERR_LEN);
      case (p)
         0:       c = ASC_E;
         1, 2, 4: c = ASC_R;
         3:       c = ASC_O;
         default: c = ASC_SPACE;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/radix_converter_seven_digit_top.sv =====
`timescale 1ns / 1ps
// radix converter top: digit accumulation, conversion sequencer, output stage
// depends on rcsd_pkg and rcsd_divider
//
// a request that is not the last digit gives no response
// a last-digit request runs seven divisions on the shared divider, each one
// start, seven 4-bit iterations, done; then the seven characters follow at
// one per cycle when responses are not stalled; the next request is taken
// once the last character has been handed to the output register
// an input error skips the divisions and goes straight to the characters.
// reset is synchronous and clears the accumulator and sequencer

module radix_converter_seven_digit_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rcsd_pkg::CHAR_IN_W-1:0]   req_digit_char,
   input  logic [rcsd_pkg::BASE_W-1:0]      req_from_base,
   input  logic [rcsd_pkg::BASE_W-1:0]      req_to_base,
   input  logic                             req_last_digit,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rcsd_pkg::CHAR_OUT_W-1:0]  rsp_out_char,
   output logic                             rsp_is_error,
   output logic                             rsp_last_char
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type                              state_ff, state_in;

   // accumulation state for the number being received
   logic [rcsd_pkg::VALUE_W-1:0]           acc_ff, acc_in;
   logic [rcsd_pkg::COUNT_W-1:0]           count_ff, count_in;
   logic                                   acc_err_ff, acc_err_in;

   // conversion state
   logic [rcsd_pkg::VALUE_W-1:0]           value_ff, value_in;
   logic [rcsd_pkg::BASE_W-1:0]            to_base_ff, to_base_in;
   logic                                   err_ff, err_in;
   logic                                   start_ff, start_in;
   logic [rcsd_pkg::IDX_W-1:0]             pos_ff, pos_in;
   logic [rcsd_pkg::DIGIT_W-1:0]           digit_ff [rcsd_pkg::FIELD_DIGITS];
   logic [rcsd_pkg::FIELD_DIGITS-1:0]      used_ff, used_in;
   logic                                   digit_we;

   // output register
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [rcsd_pkg::CHAR_OUT_W-1:0]        rsp_char_ff, rsp_char_in;
   logic                                   rsp_err_ff, rsp_err_in;
   logic                                   rsp_last_ff, rsp_last_in;

   logic                                   div_done;
   logic [rcsd_pkg::VALUE_W-1:0]           div_quot;
   logic [rcsd_pkg::DIGIT_W-1:0]           div_rem;

   // horner step on the incoming digit
   logic [rcsd_pkg::BASE_W-1:0]            digit_val;
   logic                                   digit_bad;
   logic                                   step_err;
   logic [rcsd_pkg::VALUE_W+rcsd_pkg::BASE_W:0] horner;
   logic                                   horner_ovf;
   logic                                   new_err;
   logic [rcsd_pkg::VALUE_W-1:0]           new_acc;
   logic                                   to_base_bad;
   logic                                   req_fire;
   logic                                   out_free;
   logic [rcsd_pkg::CHAR_OUT_W-1:0]        emit_char;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      digit_val  = rcsd_pkg::char_to_digit(req_digit_char);
      digit_bad  = (digit_val > rcsd_pkg::BASE_W'(15)) ||
                   (req_from_base < rcsd_pkg::BASE_MIN) ||
                   (req_from_base > rcsd_pkg::BASE_MAX) ||
                   (digit_val >= req_from_base);
      step_err   = acc_err_ff || digit_bad || (count_ff >= rcsd_pkg::COUNT_LIMIT);
      // product is formed at full width so an overflow is seen
      horner     = (rcsd_pkg::VALUE_W+rcsd_pkg::BASE_W+1)'(acc_ff)
                 * (rcsd_pkg::VALUE_W+rcsd_pkg::BASE_W+1)'(req_from_base)
                 + (rcsd_pkg::VALUE_W+rcsd_pkg::BASE_W+1)'(digit_val);
      horner_ovf = horner > (rcsd_pkg::VALUE_W+rcsd_pkg::BASE_W+1)'(rcsd_pkg::VALUE_MAX);
      new_err    = step_err || horner_ovf;
      new_acc    = new_err ? acc_ff : horner[rcsd_pkg::VALUE_W-1:0];
      to_base_bad = (req_to_base < rcsd_pkg::BASE_MIN) || (req_to_base > rcsd_pkg::BASE_MAX);
   end

   // character at the current emit position
   always_comb begin
      if (err_ff) begin
         emit_char = rcsd_pkg::err_char(pos_ff);
      end else if (used_ff[pos_ff]) begin
         emit_char = rcsd_pkg::digit_to_char(digit_ff[pos_ff]);
      end else begin
         emit_char = rcsd_pkg::ASC_SPACE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      acc_err_in   = acc_err_ff;
      value_in     = value_ff;
      to_base_in   = to_base_ff;
      err_in       = err_ff;
      start_in     = 1'b0;
      pos_in       = pos_ff;
      used_in      = used_ff;
      digit_we     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_last_digit) begin
                  // hand the number to the sequencer, start the next one clean
                  acc_in     = '0;
                  count_in   = '0;
                  acc_err_in = 1'b0;
                  value_in   = new_acc;
                  to_base_in = req_to_base;
                  err_in     = new_err || to_base_bad;
                  pos_in     = rcsd_pkg::POS_LAST;
                  if (new_err || to_base_bad) begin
                     pos_in   = '0;
                     state_in = ST_EMIT;
                  end else begin
                     start_in = 1'b1;
                     state_in = ST_DIV;
                  end
               end else begin
                  acc_in     = new_acc;
                  acc_err_in = new_err;
                  if (count_ff != rcsd_pkg::COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               digit_we        = 1'b1;
               // leading positions are blank once the value is used up
               used_in[pos_ff] = (value_ff != '0) || (pos_ff == rcsd_pkg::POS_LAST);
               value_in        = div_quot;
               if (pos_ff == '0) begin
                  // anything left needs more digits than the field has
                  err_in   = (div_quot != '0);
                  state_in = ST_EMIT;
               end else begin
                  pos_in   = pos_ff - 1'b1;
                  start_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = emit_char;
               rsp_err_in   = err_ff;
               rsp_last_in  = (pos_ff == rcsd_pkg::POS_LAST);
               if (pos_ff == rcsd_pkg::POS_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         count_ff     <= '0;
         acc_err_ff   <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         acc_err_ff   <= acc_err_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff    <= value_in;
      to_base_ff  <= to_base_in;
      err_ff      <= err_in;
      pos_ff      <= pos_in;
      used_ff     <= used_in;
      rsp_char_ff <= rsp_char_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
      if (digit_we) begin
         digit_ff[pos_ff] <= div_rem;
      end
   end

   // shared divider: one division per output digit, right to left
   rcsd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (value_ff),
      .divisor   (to_base_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_is_error  = rsp_err_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

// ===== hw/rtl/rcsd_divider.sv =====
`timescale 1ns / 1ps
// iterative restoring divider, several quotient bits per cycle
// depends on rcsd_pkg

module rcsd_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rcsd_pkg::VALUE_W-1:0]  dividend,
   input  logic [rcsd_pkg::BASE_W-1:0]   divisor,
   output logic                          done,
   output logic [rcsd_pkg::VALUE_W-1:0]  quotient,
   output logic [rcsd_pkg::DIGIT_W-1:0]  remainder
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [rcsd_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [rcsd_pkg::VALUE_W-1:0]      num_ff, num_in;
   logic [rcsd_pkg::DIGIT_W-1:0]      rem_ff, rem_in;
   logic [rcsd_pkg::BASE_W-1:0]       den_ff, den_in;

   // partial remainder stays below the divisor, so it fits in a digit
   always_comb begin
      logic [rcsd_pkg::BASE_W-1:0]   r;
      logic [rcsd_pkg::DIGIT_W-1:0]  rr;
      logic [rcsd_pkg::DIV_BITS-1:0] q;
      rr = rem_ff;
      q  = '0;
      for (int i = 0; i < rcsd_pkg::DIV_BITS; i++) begin
         r = {rr, num_ff[rcsd_pkg::VALUE_W-1-i]};
         if (r >= den_ff) begin
            r = r - den_ff;
            q[rcsd_pkg::DIV_BITS-1-i] = 1'b1;
         end
         rr = r[rcsd_pkg::DIGIT_W-1:0];
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[rcsd_pkg::VALUE_W-rcsd_pkg::DIV_BITS-1:0], q};
         rem_in = rr;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rcsd_pkg::DIV_CNT_W'(rcsd_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

// ===== tb/rcsd_field_checker.sv =====
`timescale 1ns / 1ps
// output field checker for the seven-digit radix converter: predicts each field
// from accepted digit requests and compares every accepted character; uses rcsd_pkg

module rcsd_field_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [rcsd_pkg::CHAR_IN_W-1:0]   req_digit_char,
   input  logic [rcsd_pkg::BASE_W-1:0]      req_from_base,
   input  logic [rcsd_pkg::BASE_W-1:0]      req_to_base,
   input  logic                             req_last_digit,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [rcsd_pkg::CHAR_OUT_W-1:0]  rsp_out_char,
   input  logic                             rsp_is_error,
   input  logic                             rsp_last_char,
   output int                               fault_count,
   output int                               chars_pending
);

   import rcsd_pkg::*;

   typedef struct packed {
      logic [CHAR_OUT_W-1:0] out_char;
      logic                  is_error;
      logic                  last_char;
   } field_char_type;

   localparam logic [39:0] ERROR_WORD = "ERROR";

   field_char_type       expected_chars[$];
   logic [VALUE_W-1:0]   number_value;
   logic [COUNT_W-1:0]   digits_taken;
   logic                 number_bad;

   // horner fold of one digit; on the last digit the whole field is queued
   function automatic void fold_digit(input logic [CHAR_IN_W-1:0] ch,
                                      input logic [BASE_W-1:0] from_b,
                                      input logic [BASE_W-1:0] to_b,
                                      input logic last);
      int unsigned           dval;
      longint unsigned       horner;
      int unsigned           rest;
      int unsigned           rem;
      logic                  err;
      logic [CHAR_OUT_W-1:0] line_chars [FIELD_DIGITS];
      field_char_type        fc;
      int                    k;
      dval = 16;
      if (ch >= "0" && ch <= "9") begin
         dval = ch - "0";
      end else if (ch >= "A" && ch <= "F") begin
         dval = ch - "A" + 10;
      end
      if (dval > 15 || from_b < 2 || from_b > 16 || dval >= from_b) begin
         number_bad = 1'b1;
      end
      if (digits_taken >= COUNT_LIMIT) begin
         number_bad = 1'b1;
      end
      if (digits_taken != COUNT_MAX) begin
         digits_taken = digits_taken + 1'b1;
      end
      if (!number_bad) begin
         horner = longint'(number_value) * longint'(from_b) + longint'(dval);
         if (horner > longint'(VALUE_MAX)) begin
            number_bad = 1'b1;
         end else begin
            number_value = horner[VALUE_W-1:0];
         end
      end
      if (!last) begin
         return;
      end

      err = number_bad || to_b < 2 || to_b > 16;
      for (k = 0; k < FIELD_DIGITS; k++) begin
         line_chars[k] = ASC_SPACE;
      end
      if (!err) begin
         rest = number_value;
         if (rest == 0) begin
            line_chars[FIELD_DIGITS-1] = ASC_ZERO;
         end else begin
            for (k = FIELD_DIGITS - 1; k >= 0 && rest != 0; k--) begin
               rem = rest % to_b;
               line_chars[k] = (rem < 10) ? ASC_ZERO + CHAR_OUT_W'(rem)
                                          : ASC_A + CHAR_OUT_W'(rem - 10);
               rest = rest / to_b;
            end
            // value needs more digits than the field holds
            if (rest != 0) begin
               err = 1'b1;
            end
         end
      end
      if (err) begin
         for (k = 0; k < FIELD_DIGITS; k++) begin
            line_chars[k] = ASC_SPACE;
         end
         // rightmost letters of the error word, right-justified
         for (k = 0; k < ERR_LEN && k < FIELD_DIGITS; k++) begin
            line_chars[FIELD_DIGITS-1-k] = ERROR_WORD[8*k +: CHAR_OUT_W];
         end
      end
      for (k = 0; k < FIELD_DIGITS; k++) begin
         fc.out_char  = line_chars[k];
         fc.is_error  = err;
         fc.last_char = (k == FIELD_DIGITS - 1);
         expected_chars.push_back(fc);
      end
      number_value = '0;
      digits_taken = '0;
      number_bad   = 1'b0;
   endfunction

   always @(posedge clock) begin : watch
      field_char_type want;
      field_char_type got;
      if (reset) begin
         expected_chars.delete();
         number_value  = '0;
         digits_taken  = '0;
         number_bad    = 1'b0;
         fault_count   <= 0;
         chars_pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.out_char  = rsp_out_char;
            got.is_error  = rsp_is_error;
            got.last_char = rsp_last_char;
            if (expected_chars.size() == 0) begin
               if (fault_count < 10) begin
                  $display("unexpected character %h err %b last %b",
                           got.out_char, got.is_error, got.last_char);
               end
               fault_count <= fault_count + 1;
            end else begin
               want = expected_chars.pop_front();
               if (want.out_char != got.out_char || want.is_error != got.is_error ||
                   want.last_char != got.last_char) begin
                  if (fault_count < 10) begin
                     $display("character mismatch: expected %h err %b last %b, got %h err %b last %b",
                              want.out_char, want.is_error, want.last_char,
                              got.out_char, got.is_error, got.last_char);
                  end
                  fault_count <= fault_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            fold_digit(req_digit_char, req_from_base, req_to_base, req_last_digit);
         end
         chars_pending <= expected_chars.size();
      end
   end

endmodule

// ===== tb/radix_converter_seven_digit_top_test.sv =====
`timescale 1ns / 1ps
// testbench top for the seven-digit radix converter: drives digit requests and
// response backpressure, gives the verdict; uses rcsd_pkg and rcsd_field_checker

module radix_converter_seven_digit_top_test;

   import rcsd_pkg::*;

   // generous bound on the whole run of ~160 requests
   localparam int CYCLE_LIMIT  = 200000;
   // random requests after the directed part
   localparam int RANDOM_ITEMS = 130;
   // settle time after the last character, covers a full conversion
   localparam int SETTLE_CYCLES = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CHAR_IN_W-1:0]  req_digit_char = '0;
   logic [BASE_W-1:0]     req_from_base = '0;
   logic [BASE_W-1:0]     req_to_base = '0;
   logic                  req_last_digit = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CHAR_OUT_W-1:0] rsp_out_char;
   logic                  rsp_is_error;
   logic                  rsp_last_char;

   int                    fault_count;
   int                    chars_pending;
   int                    cycle_count = 0;
   int                    requests_sent = 0;
   int unsigned           rsp_hold = 0;
   // when set, neither side idles
   bit                    steady = 1'b0;

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   radix_converter_seven_digit_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_digit_char (req_digit_char),
      .req_from_base  (req_from_base),
      .req_to_base    (req_to_base),
      .req_last_digit (req_last_digit),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_is_error   (rsp_is_error),
      .rsp_last_char  (rsp_last_char)
   );

   rcsd_field_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_digit_char (req_digit_char),
      .req_from_base  (req_from_base),
      .req_to_base    (req_to_base),
      .req_last_digit (req_last_digit),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_is_error   (rsp_is_error),
      .rsp_last_char  (rsp_last_char),
      .fault_count    (fault_count),
      .chars_pending  (chars_pending)
   );

   // watchdog: a hung handshake or a missing character ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // response side: after each character ready may be held low at random,
   // and now and then stall while the block is still converting
   always @(posedge clock) begin : rsp_side
      int unsigned hold_next;
      if (reset) begin
         rsp_hold  <= 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            hold_next = steady ? 0 : $urandom_range(0, 4);
         end else if (rsp_hold != 0) begin
            hold_next = rsp_hold - 1;
         end else if (!rsp_valid && !steady && $urandom_range(0, 7) == 0) begin
            hold_next = $urandom_range(1, 4);
         end else begin
            hold_next = 0;
         end
         rsp_hold  <= hold_next;
         rsp_ready <= (hold_next == 0);
      end
   end

   // ascii code of a digit value 0..15
   function automatic logic [CHAR_IN_W-1:0] ascii_digit(input int unsigned dval);
      return (dval < 10) ? CHAR_IN_W'("0" + dval) : CHAR_IN_W'("A" + dval - 10);
   endfunction

   // one digit request; returns at the edge where it is accepted, valid still high
   task automatic send_digit(input logic [CHAR_IN_W-1:0] ch, input logic [BASE_W-1:0] from_b,
                             input logic [BASE_W-1:0] to_b, input logic last);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_digit_char <= ch;
      req_from_base  <= from_b;
      req_to_base    <= to_b;
      req_last_digit <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   // a whole number from a string, most significant digit first
   task automatic send_text(input string digits, input int unsigned from_b,
                            input int unsigned to_b);
      int k;
      for (k = 0; k < digits.len(); k++) begin
         send_digit(digits[k], BASE_W'(from_b), BASE_W'(to_b), k == digits.len() - 1);
      end
   endtask

   // stop sending until every predicted character has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned len;
      int unsigned from_b;
      int unsigned to_b;
      int unsigned flaw_at;
      int unsigned k;
      logic [CHAR_IN_W-1:0] ch;
      logic [BASE_W-1:0]    use_from;
      logic [BASE_W-1:0]    use_to;
      int unsigned          random_start;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, widest legal value, and each error path
      send_text("0", 10, 10);
      send_text("FFFFFFF", 16, 16);
      send_text("00000000", 2, 10);           // too many digits beats the zero case
      send_digit(8'hFF, 5'd10, 5'd10, 1'b1);  // character outside 0-9, A-F
      send_digit(8'h00, 5'd0, 5'd10, 1'b1);   // null character, source base zero
      send_digit("2", 5'd2, 5'd10, 1'b1);     // digit not below the source base
      send_digit("1", 5'd31, 5'd10, 1'b1);    // source base above 16
      send_digit("5", 5'd10, 5'd1, 1'b1);     // target base below 2
      send_digit("7", 5'd10, 5'd31, 1'b1);    // target base above 16
      send_text("FFF", 16, 2);                // twelve binary digits do not fit
      wait_drained();

      // random numbers: mostly well formed, some with one broken digit, too long or with a bad target base
      random_start = requests_sent;
      while (requests_sent - random_start < RANDOM_ITEMS) begin
         steady  = ($urandom_range(0, 4) == 0);
         len     = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 9) : $urandom_range(1, 7);
         from_b  = $urandom_range(2, 16);
         to_b    = $urandom_range(2, 16);
         flaw_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : len;
         for (k = 0; k < len; k++) begin
            ch       = ascii_digit($urandom_range(0, from_b - 1));
            use_from = BASE_W'(from_b);
            use_to   = BASE_W'($urandom_range(0, 31));  // ignored before the last digit
            if (k == flaw_at) begin
               case ($urandom_range(0, 2))
                  0:       ch = CHAR_IN_W'($urandom_range(0, 255));
                  1:       ch = ascii_digit($urandom_range(from_b - 1, 15));
                  default: use_from = BASE_W'($urandom_range(0, 31));
               endcase
            end
            if (k == len - 1) begin
               use_to = ($urandom_range(0, 9) == 0) ? BASE_W'($urandom_range(0, 31))
                                                    : BASE_W'(to_b);
            end
            send_digit(ch, use_from, use_to, k == len - 1);
         end
         if ($urandom_range(0, 9) == 0) begin
            wait_drained();
         end
      end
      steady = 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
